// File: rtl/las_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// las_pkg
// shared types and codes for the local alignment score core
// ----------------------------------------------------------------------------
package las_pkg;

  localparam int SCORE_W = 12;
  localparam int SYM_W   = 3;
  localparam int CMD_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 12'd4095;

  // input commands
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DB     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd2;

  // scoring registers, broadcast to every cell
  typedef struct packed {
    logic        [3:0] match;
    logic signed [4:0] mismatch;
    logic signed [4:0] gap;
  } las_score_cfg_t;

  // control travelling with one database column down the chain
  typedef struct packed {
    logic             valid;
    logic             last;
    logic             score_en;
    logic [SYM_W-1:0] symbol;
  } las_wave_t;

  // query load and clear, broadcast to every cell
  typedef struct packed {
    logic             clear;
    logic             load;
    logic [SYM_W-1:0] symbol;
  } las_qctl_t;

endpackage : las_pkg
`default_nettype wire

// File: rtl/las_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// las_cell
// one query row: holds its base, column score and row best, scores one
// database column per transfer and passes the wavefront to the next cell
// ----------------------------------------------------------------------------
module las_cell #(
  parameter int CELL_INDEX = 0,
  parameter int ROW_W      = 9,
  parameter int COL_W      = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          advance,
  input  wire las_pkg::las_score_cfg_t cfg,
  input  wire las_pkg::las_qctl_t      qctl,
  input  wire [ROW_W-1:0]              query_count,
  input  wire las_pkg::las_wave_t      wave_in,
  input  wire [las_pkg::SCORE_W-1:0]   diag_in,
  input  wire [las_pkg::SCORE_W-1:0]   up_in,
  input  wire [COL_W-1:0]              col_in,
  input  wire [las_pkg::SCORE_W-1:0]   rbest_in,
  input  wire [ROW_W-1:0]              rrow_in,
  input  wire [COL_W-1:0]              rcol_in,
  output las_pkg::las_wave_t           wave_out,
  output logic [las_pkg::SCORE_W-1:0]  diag_out,
  output logic [las_pkg::SCORE_W-1:0]  up_out,
  output logic [COL_W-1:0]             col_out,
  output logic [las_pkg::SCORE_W-1:0]  rbest_out,
  output logic [ROW_W-1:0]             rrow_out,
  output logic [COL_W-1:0]             rcol_out
);

  localparam int SW    = las_pkg::SCORE_W;
  localparam int SUM_W = las_pkg::SCORE_W + 2;

  logic [las_pkg::SYM_W-1:0] base;
  logic                      active;
  logic [SW-1:0]             score;
  logic [SW-1:0]             best;
  logic [COL_W-1:0]          best_col;

  logic signed [SUM_W-1:0] sub_s;
  logic signed [SUM_W-1:0] gap_s;
  logic signed [SUM_W-1:0] diag_s;
  logic signed [SUM_W-1:0] up_s;
  logic signed [SUM_W-1:0] left_s;
  logic signed [SUM_W-1:0] h_raw;
  logic [SW-1:0]           h;
  logic                    scoring;
  logic [SW-1:0]           best_upd;
  logic [COL_W-1:0]        best_col_upd;
  logic                    take;
  logic                    load;

  assign load = qctl.load && (query_count == ROW_W'(CELL_INDEX));

  always_comb begin
    // substitution: zero when either base is not a real nucleotide
    if (base[2] || wave_in.symbol[2]) begin
      sub_s = '0;
    end else if (base == wave_in.symbol) begin
      sub_s = {{(SUM_W-4){1'b0}}, cfg.match};
    end else begin
      sub_s = {{(SUM_W-5){cfg.mismatch[4]}}, cfg.mismatch};
    end
    gap_s  = {{(SUM_W-5){cfg.gap[4]}}, cfg.gap};
    diag_s = $signed({2'b00, diag_in}) + sub_s;
    up_s   = $signed({2'b00, up_in}) + gap_s;
    left_s = $signed({2'b00, score}) + gap_s;

    h_raw = '0;
    if (diag_s > h_raw) h_raw = diag_s;
    if (up_s > h_raw)   h_raw = up_s;
    if (left_s > h_raw) h_raw = left_s;
    if (h_raw > $signed({2'b00, las_pkg::SCORE_MAX})) begin
      h = las_pkg::SCORE_MAX;
    end else begin
      h = h_raw[SW-1:0];
    end

    scoring = wave_in.valid && wave_in.score_en && active;
    if (scoring && (h > best)) begin
      best_upd     = h;
      best_col_upd = col_in;
    end else begin
      best_upd     = best;
      best_col_upd = best_col;
    end

    // strict compare keeps the smallest row on ties
    take = wave_in.last && active && (best_upd > rbest_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out <= '0;
      score    <= '0;
      best     <= '0;
      best_col <= '0;
      active   <= 1'b0;
    end else if (qctl.clear) begin
      score    <= '0;
      best     <= '0;
      best_col <= '0;
      active   <= 1'b0;
    end else begin
      if (load) begin
        active <= 1'b1;
      end
      if (advance) begin
        wave_out <= wave_in;
        if (wave_in.valid && wave_in.last) begin
          // end of run: row state back to zero behind the final column
          score    <= '0;
          best     <= '0;
          best_col <= '0;
        end else if (scoring) begin
          score    <= h;
          best     <= best_upd;
          best_col <= best_col_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      base <= qctl.symbol;
    end
    if (advance) begin
      diag_out <= score;
      up_out   <= h;
      col_out  <= col_in;
      if (take) begin
        rbest_out <= best_upd;
        rrow_out  <= ROW_W'(CELL_INDEX + 1);
        rcol_out  <= best_col_upd;
      end else begin
        rbest_out <= rbest_in;
        rrow_out  <= rrow_in;
        rcol_out  <= rcol_in;
      end
    end
  end

endmodule : las_cell
`default_nettype wire

// File: rtl/local_alignment_score_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// local_alignment_score_core
// smith-waterman local alignment score with a linear gap, systolic row
// ----------------------------------------------------------------------------
// Query bases are appended one per transfer into a row of QUERY_CELLS cells,
// each cell owning one query row. Database bases then stream in, one per
// cycle unless a result not yet taken stalls the chain: each base starts a
// wavefront that walks the chain one cell per cycle while it advances, so up
// to QUERY_CELLS columns are in flight at once. The database base marked last
// also carries a running best score / end position along the chain and the
// result lands in the output register once that column has passed the last
// cell. Append and clear-query commands wait until every column in flight
// has left the chain; an unknown command is taken at once and does nothing.
// A result not yet taken stalls the whole chain. No clearing pass is needed
// after reset.
// ----------------------------------------------------------------------------
module local_alignment_score_core #(
  parameter int QUERY_CELLS = 256,
  parameter int MAX_DB_LEN  = 65535,
  parameter int ROW_W       = $clog2(QUERY_CELLS + 1),
  parameter int COL_W       = $clog2(MAX_DB_LEN + 1)
) (
  input  wire                            clk,
  input  wire                            rst,
  // configuration writes
  input  wire                            cfg_valid,
  output logic                           cfg_ready,
  input  wire [las_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [las_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input items
  input  wire                            in_valid,
  output logic                           in_ready,
  input  wire [las_pkg::CMD_W-1:0]       command,
  input  wire [las_pkg::SYM_W-1:0]       symbol,
  input  wire                            last,
  // result items
  output logic                           out_valid,
  input  wire                            out_ready,
  output logic [las_pkg::SCORE_W-1:0]    best_score,
  output logic [ROW_W-1:0]               best_row,
  output logic [COL_W-1:0]               best_col,
  output logic                           query_truncated
);

  localparam int SW    = las_pkg::SCORE_W;
  localparam int CNT_W = $clog2(QUERY_CELLS + 1);

  // scoring registers
  las_pkg::las_score_cfg_t cfg;

  // run and query bookkeeping
  logic [ROW_W-1:0] query_count;
  logic [COL_W-1:0] column_count;
  logic             truncated;
  logic [CNT_W-1:0] inflight;

  logic               advance;
  logic               accept;
  logic               inject;
  logic               drain;
  logic               score_en;
  las_pkg::las_qctl_t qctl;

  // chain boundaries: index k feeds cell k, index QUERY_CELLS is the tail
  las_pkg::las_wave_t wave  [QUERY_CELLS+1];
  logic [SW-1:0]      diag  [QUERY_CELLS+1];
  logic [SW-1:0]      up    [QUERY_CELLS+1];
  logic [COL_W-1:0]   col   [QUERY_CELLS+1];
  logic [SW-1:0]      rbest [QUERY_CELLS+1];
  logic [ROW_W-1:0]   rrow  [QUERY_CELLS+1];
  logic [COL_W-1:0]   rcol  [QUERY_CELLS+1];

  // chain moves whenever the output register can take what reaches the tail
  assign advance = !out_valid || out_ready;

  // query changes only with the chain empty
  always_comb begin
    case (command)
      las_pkg::CMD_DB:     in_ready = advance;
      las_pkg::CMD_APPEND: in_ready = (inflight == '0);
      las_pkg::CMD_CLEAR:  in_ready = (inflight == '0);
      default:             in_ready = 1'b1;
    endcase
  end

  assign accept   = in_valid && in_ready;
  assign inject   = accept && (command == las_pkg::CMD_DB);
  assign drain    = wave[QUERY_CELLS].valid && advance;
  assign score_en = (column_count < COL_W'(MAX_DB_LEN));

  assign qctl.clear  = accept && (command == las_pkg::CMD_CLEAR);
  assign qctl.load   = accept && (command == las_pkg::CMD_APPEND) &&
                       (query_count != ROW_W'(QUERY_CELLS));
  assign qctl.symbol = symbol;

  // head of the chain: borders of the matrix are zero
  assign wave[0].valid    = inject;
  assign wave[0].last     = last;
  assign wave[0].score_en = score_en;
  assign wave[0].symbol   = symbol;
  assign diag[0]          = '0;
  assign up[0]            = '0;
  assign col[0]           = column_count + COL_W'(1);
  assign rbest[0]         = '0;
  assign rrow[0]          = '0;
  assign rcol[0]          = '0;

  // configuration port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match    <= 4'd5;
      cfg.mismatch <= -5'sd4;
      cfg.gap      <= -5'sd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        las_pkg::REG_MATCH:    cfg.match    <= cfg_data[3:0];
        las_pkg::REG_MISMATCH: cfg.mismatch <= $signed(cfg_data);
        las_pkg::REG_GAP:      cfg.gap      <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // query length, truncation and column position
  always_ff @(posedge clk) begin
    if (rst) begin
      query_count  <= '0;
      truncated    <= 1'b0;
      column_count <= '0;
    end else if (qctl.clear) begin
      query_count  <= '0;
      truncated    <= 1'b0;
      column_count <= '0;
    end else begin
      if (qctl.load) begin
        query_count <= query_count + ROW_W'(1);
      end else if (accept && (command == las_pkg::CMD_APPEND)) begin
        // query full: base dropped
        truncated <= 1'b1;
      end
      if (inject) begin
        if (last) begin
          column_count <= '0;
        end else if (score_en) begin
          column_count <= column_count + COL_W'(1);
        end
      end
    end
  end

  // columns in flight in the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if (inject && !drain) begin
      inflight <= inflight + CNT_W'(1);
    end else if (drain && !inject) begin
      inflight <= inflight - CNT_W'(1);
    end
  end

  // the row of cells
  for (genvar k = 0; k < QUERY_CELLS; k++) begin : g_cell
    las_cell #(
      .CELL_INDEX (k),
      .ROW_W      (ROW_W),
      .COL_W      (COL_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .cfg         (cfg),
      .qctl        (qctl),
      .query_count (query_count),
      .wave_in     (wave[k]),
      .diag_in     (diag[k]),
      .up_in       (up[k]),
      .col_in      (col[k]),
      .rbest_in    (rbest[k]),
      .rrow_in     (rrow[k]),
      .rcol_in     (rcol[k]),
      .wave_out    (wave[k+1]),
      .diag_out    (diag[k+1]),
      .up_out      (up[k+1]),
      .col_out     (col[k+1]),
      .rbest_out   (rbest[k+1]),
      .rrow_out    (rrow[k+1]),
      .rcol_out    (rcol[k+1])
    );
  end

  // output register: a final column leaving the tail becomes the result
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= wave[QUERY_CELLS].valid && wave[QUERY_CELLS].last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && wave[QUERY_CELLS].valid && wave[QUERY_CELLS].last) begin
      best_score      <= rbest[QUERY_CELLS];
      best_row        <= rrow[QUERY_CELLS];
      best_col        <= rcol[QUERY_CELLS];
      query_truncated <= truncated;
    end
  end

endmodule : local_alignment_score_core
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the local alignment score core
// ----------------------------------------------------------------------------
// Drives query loads, database streams and scoring register writes through
// valid/ready channels, with random idle bursts on both sides. A scoreboard
// class keeps its own copy of the score matrix state, predicts every result
// of a database base marked last, and checks each result transfer field by
// field in order. Covers empty, full and overflowing queries, appends in the
// middle of a run, non-ACGT codes, ignored commands and extreme scoring
// registers.
// ----------------------------------------------------------------------------
module tb;

  localparam int QUERY_CELLS  = 256;
  localparam int MAX_DB_LEN   = 65535;
  localparam int ROW_W        = 9;
  localparam int COL_W        = 16;
  // give a column time to leave the chain, with some slack
  localparam int DRAIN_CYCLES = QUERY_CELLS + 64;
  // cycles without any transfer before the run is declared hung
  localparam int QUIET_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 1470;
  localparam int PHASES       = 7;

  // command code the block must take and ignore
  localparam logic [las_pkg::CMD_W-1:0]     CMD_NONE  = 2'd3;
  // register index with no register behind it
  localparam logic [las_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  // base codes; anything above T scores zero
  localparam logic [las_pkg::SYM_W-1:0] SYM_G  = 3'd0;
  localparam logic [las_pkg::SYM_W-1:0] SYM_C  = 3'd1;
  localparam logic [las_pkg::SYM_W-1:0] SYM_A  = 3'd2;
  localparam logic [las_pkg::SYM_W-1:0] SYM_T  = 3'd3;
  localparam logic [las_pkg::SYM_W-1:0] SYM_N  = 3'd4;
  localparam logic [las_pkg::SYM_W-1:0] SYM_X7 = 3'd7;

  typedef struct packed {
    logic [las_pkg::SCORE_W-1:0] score;
    logic [ROW_W-1:0]            row;
    logic [COL_W-1:0]            col;
    logic                        trunc;
  } align_result_t;

  // --------------------------------------------------------------------------
  // alignment score predictor and result checker
  // --------------------------------------------------------------------------
  class align_scoreboard;
    logic [las_pkg::SYM_W-1:0] query_base [QUERY_CELLS];
    int                query_len;
    int                col_score [QUERY_CELLS];
    int                row_best [QUERY_CELLS];
    int                row_best_col [QUERY_CELLS];
    int                columns_done;
    bit                dropped;
    logic [3:0]        match_sc;
    logic signed [4:0] mismatch_sc;
    logic signed [4:0] gap_sc;
    align_result_t     expected_q[$];
    int                mismatches;

    function new();
      query_len   = 0;
      dropped     = 0;
      mismatches  = 0;
      match_sc    = 4'd5;
      mismatch_sc = -5'sd4;
      gap_sc      = -5'sd10;
      clear_run();
    endfunction

    function void clear_run();
      for (int r = 0; r < QUERY_CELLS; r++) begin
        col_score[r]    = 0;
        row_best[r]     = 0;
        row_best_col[r] = 0;
      end
      columns_done = 0;
    endfunction

    function void set_register(logic [las_pkg::CFG_IDX_W-1:0] idx,
                               logic [las_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        las_pkg::REG_MATCH:    match_sc    = data[3:0];
        las_pkg::REG_MISMATCH: mismatch_sc = signed'(data);
        las_pkg::REG_GAP:      gap_sc      = signed'(data);
        default: ;
      endcase
    endfunction

    function int sub_score(logic [las_pkg::SYM_W-1:0] q, logic [las_pkg::SYM_W-1:0] d);
      if (q > SYM_T || d > SYM_T) return 0;
      return (q == d) ? int'(match_sc) : int'(mismatch_sc);
    endfunction

    // one database base fills one matrix column, top row first
    function void score_column(logic [las_pkg::SYM_W-1:0] d);
      int diag, up, left, h, c;
      diag = 0;
      up   = 0;
      columns_done++;
      for (int r = 0; r < query_len; r++) begin
        left = col_score[r];
        h = 0;
        c = diag + sub_score(query_base[r], d);
        if (c > h) h = c;
        c = up + int'(gap_sc);
        if (c > h) h = c;
        c = left + int'(gap_sc);
        if (c > h) h = c;
        if (h > int'(las_pkg::SCORE_MAX)) h = int'(las_pkg::SCORE_MAX);
        col_score[r] = h;
        if (h > row_best[r]) begin
          row_best[r]     = h;
          row_best_col[r] = columns_done;
        end
        diag = left;
        up   = h;
      end
    endfunction

    function void note_input(logic [las_pkg::CMD_W-1:0] cmd,
                             logic [las_pkg::SYM_W-1:0] sym, logic lst);
      align_result_t res;
      int top;
      case (cmd)
        las_pkg::CMD_APPEND: begin
          if (query_len < QUERY_CELLS) begin
            query_base[query_len] = sym;
            query_len++;
          end else begin
            dropped = 1;
          end
        end
        las_pkg::CMD_CLEAR: begin
          query_len = 0;
          dropped   = 0;
          clear_run();
        end
        las_pkg::CMD_DB: begin
          if (columns_done < MAX_DB_LEN) score_column(sym);
          if (lst) begin
            // first maximum in row-major order: smallest row wins ties
            top = 0;
            res = '0;
            for (int r = 0; r < query_len; r++) begin
              if (row_best[r] > top) begin
                top       = row_best[r];
                res.score = las_pkg::SCORE_W'(top);
                res.row   = ROW_W'(r + 1);
                res.col   = COL_W'(row_best_col[r]);
              end
            end
            res.trunc = dropped;
            expected_q.push_back(res);
            clear_run();
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    task check_result(align_result_t got);
      align_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result score %0d row %0d col %0d trunc %0d",
                                  got.score, got.row, got.col, got.trunc));
        return;
      end
      want = expected_q.pop_front();
      if (got.score != want.score)
        report_mismatch($sformatf("best_score %0d, want %0d", got.score, want.score));
      if (got.row != want.row)
        report_mismatch($sformatf("best_row %0d, want %0d", got.row, want.row));
      if (got.col != want.col)
        report_mismatch($sformatf("best_col %0d, want %0d", got.col, want.col));
      if (got.trunc != want.trunc)
        report_mismatch($sformatf("query_truncated %0d, want %0d", got.trunc, want.trunc));
    endtask

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block hookup
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [las_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [las_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [las_pkg::CMD_W-1:0]      command  = las_pkg::CMD_APPEND;
  logic [las_pkg::SYM_W-1:0]      symbol   = SYM_G;
  logic                           last     = 1'b0;

  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [las_pkg::SCORE_W-1:0]    best_score;
  logic [ROW_W-1:0]               best_row;
  logic [COL_W-1:0]               best_col;
  logic                           query_truncated;

  align_scoreboard sb;
  align_result_t   seen;
  bit              idle_on = 1'b1;
  int              items_sent = 0;
  int              quiet_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  local_alignment_score_core dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .symbol          (symbol),
    .last            (last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .best_score      (best_score),
    .best_row        (best_row),
    .best_col        (best_col),
    .query_truncated (query_truncated)
  );

  // --------------------------------------------------------------------------
  // result side: random back-pressure bursts, checking on every transfer
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen = '{best_score, best_row, best_col, query_truncated};
      sb.check_result(seen);
    end
  end

  // watchdog: the run is hung once no channel has moved for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // mostly real bases so that matches happen; now and then a non-ACGT code
  function automatic logic [las_pkg::SYM_W-1:0] rand_symbol();
    if ($urandom_range(0, 7) == 0) return las_pkg::SYM_W'($urandom_range(SYM_N, SYM_X7));
    return las_pkg::SYM_W'($urandom_range(SYM_G, SYM_T));
  endfunction

  // one input transfer; valid stays up afterwards unless the caller drops it
  task automatic send_item(input logic [las_pkg::CMD_W-1:0] cmd,
                           input logic [las_pkg::SYM_W-1:0] sym,
                           input logic lst);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    symbol   <= sym;
    last     <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(cmd, sym, lst);
    if (cmd != CMD_NONE) items_sent++;
  endtask

  task automatic write_register(input logic [las_pkg::CFG_IDX_W-1:0] idx,
                                input logic [las_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid, wait for every result, then let any trailing column drain
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // mostly complete runs (optional clear, query load, database ending in
  // last), mixed with ignored commands, stray marks and unfinished streams
  task automatic random_phase(input int budget);
    int start, k, m, src;
    bit copy_mode;
    logic [las_pkg::SYM_W-1:0] s;
    start = items_sent;
    while (items_sent - start < budget) begin
      case ($urandom_range(0, 19))
        0: send_item(CMD_NONE, rand_symbol(), 1'($urandom_range(0, 1)));
        1: send_item(las_pkg::CMD_CLEAR, rand_symbol(), 1'($urandom_range(0, 1)));
        2: send_item(las_pkg::CMD_APPEND, rand_symbol(), 1'($urandom_range(0, 1)));
        3: repeat ($urandom_range(1, 6)) send_item(las_pkg::CMD_DB, rand_symbol(), 1'b0);
        default: begin
          if ($urandom_range(0, 2) == 0) send_item(las_pkg::CMD_CLEAR, rand_symbol(), 1'b0);
          // now and then a query that fills the row and spills over
          k = ($urandom_range(0, 15) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 10);
          repeat (k) send_item(las_pkg::CMD_APPEND, rand_symbol(), 1'b0);
          m = $urandom_range(1, 16);
          // copying a stretch of the query gives long diagonals and big scores
          copy_mode = 1'($urandom_range(0, 1));
          src = $urandom_range(0, sb.query_len - 1);
          for (int j = 0; j < m; j++) begin
            if (copy_mode && src + j < sb.query_len && $urandom_range(0, 5) != 0)
              s = sb.query_base[src + j];
            else
              s = rand_symbol();
            send_item(las_pkg::CMD_DB, s, j == m - 1);
          end
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset scoring registers
    // empty query gives an all-zero result
    send_item(las_pkg::CMD_DB, SYM_G, 1'b1);
    // the four bases, N and code 7, plus a stray last mark on an append
    send_item(las_pkg::CMD_APPEND, SYM_G, 1'b0);
    send_item(las_pkg::CMD_APPEND, SYM_C, 1'b0);
    send_item(las_pkg::CMD_APPEND, SYM_A, 1'b0);
    send_item(las_pkg::CMD_APPEND, SYM_T, 1'b0);
    send_item(las_pkg::CMD_APPEND, SYM_N, 1'b0);
    send_item(las_pkg::CMD_APPEND, SYM_X7, 1'b1);
    // unknown command with last set does nothing
    send_item(CMD_NONE, SYM_X7, 1'b1);
    send_item(las_pkg::CMD_DB, SYM_G, 1'b0);
    send_item(las_pkg::CMD_DB, SYM_C, 1'b0);
    send_item(las_pkg::CMD_DB, SYM_A, 1'b0);
    send_item(las_pkg::CMD_DB, SYM_T, 1'b0);
    send_item(las_pkg::CMD_DB, 3'd6, 1'b1);
    // append in the middle of a run: the new row starts with no history
    send_item(las_pkg::CMD_DB, SYM_G, 1'b0);
    send_item(las_pkg::CMD_APPEND, SYM_G, 1'b0);
    send_item(las_pkg::CMD_DB, SYM_C, 1'b0);
    send_item(las_pkg::CMD_DB, SYM_G, 1'b1);
    // clear query with a stray mark, then an empty-query result again
    send_item(las_pkg::CMD_CLEAR, SYM_A, 1'b1);
    send_item(las_pkg::CMD_DB, SYM_A, 1'b1);

    // full query: only the last row can score, then two dropped appends
    for (int i = 0; i < QUERY_CELLS - 1; i++)
      send_item(las_pkg::CMD_APPEND, SYM_N + las_pkg::SYM_W'(i % 4), 1'b0);
    send_item(las_pkg::CMD_APPEND, SYM_G, 1'b0);
    send_item(las_pkg::CMD_APPEND, SYM_T, 1'b0);
    send_item(las_pkg::CMD_APPEND, SYM_C, 1'b0);
    send_item(las_pkg::CMD_DB, SYM_G, 1'b1);
    // clearing drops the truncation flag too
    send_item(las_pkg::CMD_CLEAR, SYM_G, 1'b0);
    send_item(las_pkg::CMD_DB, SYM_G, 1'b1);
    settle();

    // random part, one scoring setting per phase
    items_sent = 0;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          write_register(las_pkg::REG_MATCH, 5'd15);
          write_register(las_pkg::REG_MISMATCH, 5'd0);
          write_register(las_pkg::REG_GAP, 5'd0);
        end
        1: begin
          write_register(las_pkg::REG_MATCH, 5'd0);
          write_register(las_pkg::REG_MISMATCH, 5'b10000);
          write_register(las_pkg::REG_GAP, 5'b10000);
        end
        default: begin
          if (phase == 2)
            write_register(REG_SPARE, las_pkg::CFG_DATA_W'($urandom_range(0, 31)));
          write_register(las_pkg::REG_MATCH, las_pkg::CFG_DATA_W'($urandom_range(0, 15)));
          write_register(las_pkg::REG_MISMATCH,
                         las_pkg::CFG_DATA_W'(-int'($urandom_range(0, 16))));
          write_register(las_pkg::REG_GAP,
                         las_pkg::CFG_DATA_W'(-int'($urandom_range(0, 16))));
        end
      endcase
      // no idling in the final phase, some phases without it as well
      idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
      random_phase(RANDOM_ITEMS / PHASES);
      settle();
    end

    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
